>>> rtl/thrust_allocation_split_matrix_macros.svh
// Assertion macros used by the RTL file that carries checks.
// Each macro samples on the rising edge of clock and is disabled during reset.
`ifndef THRUST_ALLOCATION_SPLIT_MATRIX_MACROS_SVH
`define THRUST_ALLOCATION_SPLIT_MATRIX_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TASM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("thrust allocation check failed");

// The consequent must hold in the cycle after the antecedent.
`define TASM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("thrust allocation check failed");

`endif

>>> rtl/tasm_pkg.sv
`default_nettype none

package tasm_pkg;

   localparam int NUM_FANS    = 8;
   localparam int NUM_AXES    = 6;
   localparam int OUT_FANS    = 8;
   localparam int TABLE_DEPTH = NUM_FANS * NUM_AXES;
   localparam int TABLE_IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam int DEMAND_W   = 24;
   localparam int MAG_W      = 24;
   localparam int COEF_W     = 16;
   localparam int PROD_W     = MAG_W + COEF_W;
   localparam int FRAC_SHIFT = 14;
   localparam int TERM_W     = 25;
   localparam int THRUST_W   = 28;
   localparam int SEL_W      = 3;
   localparam int LOAD_IDX_W = 6;

   localparam int LATENCY = 6;

   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_COMPUTE = 1'b1;

   typedef logic signed [DEMAND_W-1:0] demand_type;
   typedef logic [MAG_W-1:0]           mag_type;
   typedef logic [COEF_W-1:0]          coef_type;
   typedef logic [PROD_W-1:0]          prod_type;
   typedef logic [TERM_W-1:0]          term_type;
   typedef logic [THRUST_W-1:0]        thrust_type;
   typedef logic [SEL_W-1:0]           sel_type;
   typedef logic [TABLE_IDX_W-1:0]     table_idx_type;
   typedef logic [LOAD_IDX_W-1:0]      load_idx_type;

endpackage

`default_nettype wire

>>> rtl/thrust_allocation_split_matrix.sv
// Thrust allocation with split direction tables. A compute transfer (req_kind high)
// carries a six-axis force/torque demand; each fan's thrust is the sum over the
// axes of the demand magnitude times the fan's coefficient from the positive or
// negative table, with the smallest fan sum then removed from all fans. A load
// transfer (req_kind low) writes one coefficient, if its fan and axis are in range,
// and gives no result; a compute transfer accepted in the next cycle already uses
// it. The block takes one transfer in every cycle, so busy is always low. Each
// result appears on the rsp_ ports with rsp_valid for one cycle, after its compute
// transfer has passed an input register, one stage of multipliers (one per fan and
// axis), a fan sum stage, two stages of the minimum tree and the result register.
// The receiver cannot stall, so every result must be taken in the cycle it is shown.
// Reset clears both coefficient tables at once.
`default_nettype none
`include "thrust_allocation_split_matrix_macros.svh"

module thrust_allocation_split_matrix
   import tasm_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic                       req_kind,
   input  wire logic signed [DEMAND_W-1:0] req_demand_fx,
   input  wire logic signed [DEMAND_W-1:0] req_demand_fy,
   input  wire logic signed [DEMAND_W-1:0] req_demand_fz,
   input  wire logic signed [DEMAND_W-1:0] req_demand_tx,
   input  wire logic signed [DEMAND_W-1:0] req_demand_ty,
   input  wire logic signed [DEMAND_W-1:0] req_demand_tz,
   input  wire logic [SEL_W-1:0]           req_load_fan,
   input  wire logic [SEL_W-1:0]           req_load_axis,
   input  wire logic                       req_load_negative,
   input  wire logic [COEF_W-1:0]          req_load_value,
   output logic                            rsp_valid,
   output logic [THRUST_W-1:0]             rsp_thrust_fan0,
   output logic [THRUST_W-1:0]             rsp_thrust_fan1,
   output logic [THRUST_W-1:0]             rsp_thrust_fan2,
   output logic [THRUST_W-1:0]             rsp_thrust_fan3,
   output logic [THRUST_W-1:0]             rsp_thrust_fan4,
   output logic [THRUST_W-1:0]             rsp_thrust_fan5,
   output logic [THRUST_W-1:0]             rsp_thrust_fan6,
   output logic [THRUST_W-1:0]             rsp_thrust_fan7
);

   logic          accept;
   logic          load_write;
   load_idx_type  load_idx_wide;
   table_idx_type load_idx;

   coef_type      pos_coef_ff [TABLE_DEPTH];
   coef_type      neg_coef_ff [TABLE_DEPTH];

   logic          s1_valid_in, s1_valid_ff;
   mag_type       s1_mag_in [NUM_AXES];
   mag_type       s1_mag_ff [NUM_AXES];
   logic          s1_neg_in [NUM_AXES];
   logic          s1_neg_ff [NUM_AXES];
   demand_type    demand [NUM_AXES];

   logic          s2_valid_in, s2_valid_ff;
   term_type      s2_term_in [NUM_FANS][NUM_AXES];
   term_type      s2_term_ff [NUM_FANS][NUM_AXES];

   logic          s3_valid_in, s3_valid_ff;
   thrust_type    s3_sum_in [OUT_FANS];
   thrust_type    s3_sum_ff [OUT_FANS];

   logic          s4_valid_in, s4_valid_ff;
   thrust_type    s4_min_in [OUT_FANS/2];
   thrust_type    s4_min_ff [OUT_FANS/2];
   thrust_type    s4_sum_ff [OUT_FANS];
   thrust_type    pad_sum [OUT_FANS];

   logic          s5_valid_in, s5_valid_ff;
   thrust_type    s5_min_in, s5_min_ff;
   thrust_type    s5_sum_ff [OUT_FANS];
   thrust_type    min_lo, min_hi;

   logic          rsp_valid_in, rsp_valid_ff;
   thrust_type    thrust_in [OUT_FANS];
   thrust_type    thrust_ff [OUT_FANS];
   logic          any_fan_zero;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign load_idx_wide = LOAD_IDX_W'(req_load_fan) * LOAD_IDX_W'(NUM_AXES)
                        + LOAD_IDX_W'(req_load_axis);
   assign load_idx      = load_idx_wide[TABLE_IDX_W-1:0];
   assign load_write    = accept && (req_kind == KIND_LOAD)
                        && ({1'b0, req_load_fan} < (SEL_W+1)'(NUM_FANS))
                        && (req_load_axis < SEL_W'(NUM_AXES));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            pos_coef_ff[i] <= '0;
            neg_coef_ff[i] <= '0;
         end
      end else if (load_write) begin
         if (req_load_negative) begin
            neg_coef_ff[load_idx] <= req_load_value;
         end else begin
            pos_coef_ff[load_idx] <= req_load_value;
         end
      end
   end

   assign demand[0] = req_demand_fx;
   assign demand[1] = req_demand_fy;
   assign demand[2] = req_demand_fz;
   assign demand[3] = req_demand_tx;
   assign demand[4] = req_demand_ty;
   assign demand[5] = req_demand_tz;

   // The magnitude of the most negative demand still fits as an unsigned value.
   always_comb begin
      s1_valid_in = accept && (req_kind == KIND_COMPUTE);
      for (int a = 0; a < NUM_AXES; a++) begin
         s1_neg_in[a] = demand[a][DEMAND_W-1];
         s1_mag_in[a] = s1_neg_in[a] ? (~mag_type'(demand[a]) + mag_type'(1))
                                     : mag_type'(demand[a]);
      end
   end

   always_comb begin
      prod_type prod;
      coef_type coef;
      s2_valid_in = s1_valid_ff;
      for (int f = 0; f < NUM_FANS; f++) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            coef = s1_neg_ff[a] ? neg_coef_ff[f*NUM_AXES+a] : pos_coef_ff[f*NUM_AXES+a];
            prod = prod_type'(s1_mag_ff[a]) * prod_type'(coef);
            s2_term_in[f][a] = prod[FRAC_SHIFT +: TERM_W];
         end
      end
   end

   always_comb begin
      s3_valid_in = s2_valid_ff;
      for (int f = 0; f < OUT_FANS; f++) begin
         s3_sum_in[f] = '0;
      end
      for (int f = 0; f < NUM_FANS; f++) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            s3_sum_in[f] = s3_sum_in[f] + THRUST_W'(s2_term_ff[f][a]);
         end
      end
   end

   // Fans that are not present sit at full scale so they never win the minimum.
   always_comb begin
      s4_valid_in = s3_valid_ff;
      for (int f = 0; f < OUT_FANS; f++) begin
         pad_sum[f] = (f < NUM_FANS) ? s3_sum_ff[f] : '1;
      end
      for (int i = 0; i < OUT_FANS/2; i++) begin
         s4_min_in[i] = (pad_sum[2*i] < pad_sum[2*i+1]) ? pad_sum[2*i] : pad_sum[2*i+1];
      end
   end

   always_comb begin
      s5_valid_in = s4_valid_ff;
      min_lo      = (s4_min_ff[0] < s4_min_ff[1]) ? s4_min_ff[0] : s4_min_ff[1];
      min_hi      = (s4_min_ff[2] < s4_min_ff[3]) ? s4_min_ff[2] : s4_min_ff[3];
      s5_min_in   = (min_lo < min_hi) ? min_lo : min_hi;
   end

   always_comb begin
      rsp_valid_in = s5_valid_ff;
      for (int f = 0; f < OUT_FANS; f++) begin
         thrust_in[f] = (f < NUM_FANS) ? (s5_sum_ff[f] - s5_min_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         s5_valid_ff  <= s5_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_mag_ff  <= s1_mag_in;
      s1_neg_ff  <= s1_neg_in;
      s2_term_ff <= s2_term_in;
      s3_sum_ff  <= s3_sum_in;
      s4_min_ff  <= s4_min_in;
      s4_sum_ff  <= s3_sum_ff;
      s5_min_ff  <= s5_min_in;
      s5_sum_ff  <= s4_sum_ff;
      thrust_ff  <= thrust_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_thrust_fan0 = thrust_ff[0];
   assign rsp_thrust_fan1 = thrust_ff[1];
   assign rsp_thrust_fan2 = thrust_ff[2];
   assign rsp_thrust_fan3 = thrust_ff[3];
   assign rsp_thrust_fan4 = thrust_ff[4];
   assign rsp_thrust_fan5 = thrust_ff[5];
   assign rsp_thrust_fan6 = thrust_ff[6];
   assign rsp_thrust_fan7 = thrust_ff[7];

   always_comb begin
      any_fan_zero = 1'b0;
      for (int f = 0; f < OUT_FANS; f++) begin
         any_fan_zero = any_fan_zero || (thrust_ff[f] == '0);
      end
   end

   `TASM_ASSERT_SAME(a_compute_gives_result, accept && (req_kind == KIND_COMPUTE), ##6 rsp_valid)
   `TASM_ASSERT_SAME(a_load_gives_none, accept && (req_kind == KIND_LOAD), ##6 !rsp_valid)
   `TASM_ASSERT_SAME(a_min_fan_zero, rsp_valid, any_fan_zero)
   `TASM_ASSERT_NEXT(a_pos_load_lands, load_write && !req_load_negative, pos_coef_ff[$past(load_idx)] == $past(req_load_value))
   `TASM_ASSERT_NEXT(a_neg_load_lands, load_write && req_load_negative, neg_coef_ff[$past(load_idx)] == $past(req_load_value))

endmodule

`default_nettype wire
